@@ hdl/tacs_pkg.sv @@
// shared constants and types of the traffic automaton car step block
`default_nettype none

package tacs_pkg;

   // fixed field widths
   localparam int LEN_BITS    = 16;
   localparam int CARS_BITS   = 7;
   localparam int SPEED_BITS  = 5;
   localparam int THR_BITS    = 17;
   localparam int IDX_BITS    = 6;
   localparam int RND_BITS    = 16;
   localparam int OUT_CELL_BITS = 16;
   localparam int LAP_BITS    = 32;

   // register port
   localparam int DATA_BITS   = 32;
   localparam int ADDR_BITS   = 4;

   // parameter defaults
   localparam int MAX_CARS_DEFAULT  = 64;
   localparam int CELL_BITS_DEFAULT = 16;

   // register indexes
   localparam logic [1:0] REG_ROAD_LENGTH    = 2'd0;
   localparam logic [1:0] REG_CARS_IN_USE    = 2'd1;
   localparam logic [1:0] REG_SPEED_LIMIT    = 2'd2;
   localparam logic [1:0] REG_SLOW_THRESHOLD = 2'd3;

   // register reset values
   localparam logic [LEN_BITS-1:0]   ROAD_LENGTH_RESET    = 16'd1000;
   localparam logic [CARS_BITS-1:0]  CARS_IN_USE_RESET    = 7'd1;
   localparam logic [SPEED_BITS-1:0] SPEED_LIMIT_RESET    = 5'd5;
   localparam logic [THR_BITS-1:0]   SLOW_THRESHOLD_RESET = 17'd0;

   // item kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   // configuration register set
   typedef struct packed {
      logic [LEN_BITS-1:0]   road_length;
      logic [CARS_BITS-1:0]  cars_in_use;
      logic [SPEED_BITS-1:0] speed_limit;
      logic [THR_BITS-1:0]   slow_threshold;
   } cfg_type;

   // answer of the gap unit
   typedef struct packed {
      logic                vld;
      logic [LEN_BITS-1:0] gap;
   } gap_rsp_type;

endpackage

`default_nettype wire

@@ hdl/tacs_csr.sv @@
// configuration registers behind the apb-style port
`default_nettype none

module tacs_csr
   import tacs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [ADDR_BITS-1:0] paddr,
   input  wire logic [DATA_BITS-1:0] pwdata,
   output      logic [DATA_BITS-1:0] prdata,
   output      logic                 pready,
   output      cfg_type              cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.road_length    <= ROAD_LENGTH_RESET;
         cfg_ff.cars_in_use    <= CARS_IN_USE_RESET;
         cfg_ff.speed_limit    <= SPEED_LIMIT_RESET;
         cfg_ff.slow_threshold <= SLOW_THRESHOLD_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_ROAD_LENGTH:    cfg_ff.road_length    <= pwdata[LEN_BITS-1:0];
            REG_CARS_IN_USE:    cfg_ff.cars_in_use    <= pwdata[CARS_BITS-1:0];
            REG_SPEED_LIMIT:    cfg_ff.speed_limit    <= pwdata[SPEED_BITS-1:0];
            REG_SLOW_THRESHOLD: cfg_ff.slow_threshold <= pwdata[THR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         REG_ROAD_LENGTH:    prdata = DATA_BITS'(cfg_ff.road_length);
         REG_CARS_IN_USE:    prdata = DATA_BITS'(cfg_ff.cars_in_use);
         REG_SPEED_LIMIT:    prdata = DATA_BITS'(cfg_ff.speed_limit);
         REG_SLOW_THRESHOLD: prdata = DATA_BITS'(cfg_ff.slow_threshold);
         default:            prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ hdl/tacs_gap.sv @@
// gap ahead of a car: direct range fold, or a bit-serial remainder for far cells
`default_nettype none

module tacs_gap
   import tacs_pkg::*;
#(
   parameter int DW = 17
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_vld,
   input  wire logic [DW-1:0]       gap_diff,
   input  wire logic [LEN_BITS-1:0] road_cells,
   input  wire logic                take,
   output      gap_rsp_type         rsp
);

   localparam int CNT_BITS = $clog2(DW + 1);
   localparam int REM_BITS = LEN_BITS + 1;

   typedef enum logic [1:0] {GAP_IDLE, GAP_RUN, GAP_DONE} gap_state_type;

   gap_state_type         state_ff;
   logic [DW-1:0]         mag_ff;
   logic [LEN_BITS-1:0]   rem_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic                  neg_ff;

   logic                  neg;
   logic [DW-1:0]         len_x;
   logic [DW-1:0]         sum;
   logic                  in_pos;
   logic                  in_neg;
   logic                  fast;
   logic [LEN_BITS-1:0]   fast_gap;
   logic [DW-1:0]         mag;
   logic [REM_BITS-1:0]   shifted;
   logic [REM_BITS-1:0]   rem_in;
   logic [LEN_BITS-1:0]   slow_gap;

   // difference already within one road length of the range
   assign neg      = gap_diff[DW-1];
   assign len_x    = DW'(road_cells);
   assign sum      = gap_diff + len_x;
   assign in_pos   = !neg && (gap_diff < len_x);
   assign in_neg   = neg && !sum[DW-1];
   assign fast     = in_pos | in_neg;
   assign fast_gap = neg ? sum[LEN_BITS-1:0] : gap_diff[LEN_BITS-1:0];
   assign mag      = neg ? (~gap_diff + DW'(1)) : gap_diff;

   // one remainder bit per cycle
   assign shifted  = {rem_ff, mag_ff[DW-1]};
   assign rem_in   = (shifted >= REM_BITS'(road_cells)) ? shifted - REM_BITS'(road_cells)
                                                        : shifted;

   // fold the magnitude remainder back for a negative difference
   assign slow_gap = (neg_ff && rem_ff != '0) ? road_cells - rem_ff : rem_ff;

   assign rsp.vld  = req_vld & (fast | (state_ff == GAP_DONE));
   assign rsp.gap  = fast ? fast_gap : slow_gap;

   // remainder sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GAP_IDLE;
      end else begin
         case (state_ff)
            GAP_IDLE: begin
               if (req_vld && !fast) begin
                  mag_ff   <= mag;
                  rem_ff   <= '0;
                  cnt_ff   <= CNT_BITS'(DW);
                  neg_ff   <= neg;
                  state_ff <= GAP_RUN;
               end
            end
            GAP_RUN: begin
               rem_ff <= rem_in[LEN_BITS-1:0];
               mag_ff <= mag_ff << 1;
               cnt_ff <= cnt_ff - CNT_BITS'(1);
               if (cnt_ff == CNT_BITS'(1)) begin
                  state_ff <= GAP_DONE;
               end
            end
            GAP_DONE: begin
               if (take) begin
                  state_ff <= GAP_IDLE;
               end
            end
            default: state_ff <= GAP_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

@@ hdl/traffic_automaton_car_step.sv @@
// an accepted item passes through the work stage, then the result register
// throughput: one item per cycle while the cells of the cars lie on the road and rsp_stall is low
// a step whose gap difference lies beyond one road length runs the serial
// remainder unit and holds the stage until the remainder is done
// reset: synchronous; clears registers, speeds and laps (valid bits), turn
// pointer and saved first cell; car cells stay undefined until loaded
`default_nettype none

module traffic_automaton_car_step
   import tacs_pkg::*;
#(
   parameter int MAX_CARS  = MAX_CARS_DEFAULT,
   parameter int CELL_BITS = CELL_BITS_DEFAULT
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // input items
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic                     req_kind,
   input  wire logic [IDX_BITS-1:0]      req_car_index,
   input  wire logic [LEN_BITS-1:0]      req_start_cell,
   input  wire logic [RND_BITS-1:0]      req_random_value,
   // result items
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic [IDX_BITS-1:0]      rsp_car_id,
   output      logic [OUT_CELL_BITS-1:0] rsp_new_cell,
   output      logic [SPEED_BITS-1:0]    rsp_new_speed,
   output      logic [LAP_BITS-1:0]      rsp_lap_count,
   output      logic                     rsp_tick_done,
   // configuration
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [ADDR_BITS-1:0]     csr_paddr,
   input  wire logic [DATA_BITS-1:0]     csr_pwdata,
   output      logic [DATA_BITS-1:0]     csr_prdata,
   output      logic                     csr_pready
);

   localparam int CAR_BITS  = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_CARS + 1);
   localparam int CMP_BITS  = (CNT_BITS > CARS_BITS) ? CNT_BITS : CARS_BITS;
   localparam int CMPI_BITS = (CMP_BITS > IDX_BITS) ? CMP_BITS : IDX_BITS;
   localparam int WIDE_BITS = (CELL_BITS > LEN_BITS) ? CELL_BITS : LEN_BITS;
   localparam int DW        = WIDE_BITS + 1;

   cfg_type cfg;

   // car store
   logic [CELL_BITS-1:0]  cell_mem [MAX_CARS];
   logic [SPEED_BITS-1:0] spd_mem  [MAX_CARS];
   logic [LAP_BITS-1:0]   lap_mem  [MAX_CARS];
   logic [MAX_CARS-1:0]   sl_vld_ff;

   // turn and saved first cell
   logic [CAR_BITS-1:0]   turn_ff;
   logic [CELL_BITS-1:0]  first_old_ff;

   // work stage
   logic                  s_vld_ff;
   logic                  s_kind_ff;
   logic [CAR_BITS-1:0]   s_car_ff;
   logic [IDX_BITS-1:0]   s_idx_ff;
   logic                  s_in_store_ff;
   logic [CELL_BITS-1:0]  s_start_ff;
   logic [RND_BITS-1:0]   s_rnd_ff;
   logic                  s_last_ff;
   logic [CELL_BITS-1:0]  s_own_ff;
   logic [CELL_BITS-1:0]  s_next_ff;
   logic [SPEED_BITS-1:0] s_spd_ff;
   logic [LAP_BITS-1:0]   s_laps_ff;

   // result register
   logic                     o_vld_ff;
   logic [IDX_BITS-1:0]      o_car_ff;
   logic [OUT_CELL_BITS-1:0] o_cell_ff;
   logic [SPEED_BITS-1:0]    o_spd_ff;
   logic [LAP_BITS-1:0]      o_laps_ff;
   logic                     o_tick_ff;

   logic                  acc;
   logic                  fire;
   logic                  step;
   logic [LEN_BITS-1:0]   eff_len;
   logic [CMP_BITS-1:0]   eff_n;
   logic [CAR_BITS-1:0]   c_acc;
   logic                  last_acc;
   logic [CAR_BITS-1:0]   next_addr;
   logic                  in_store;
   logic                  bypass_own;
   logic                  bypass_next;
   logic [CELL_BITS-1:0]  first_eff;
   logic [CELL_BITS-1:0]  next_cell;
   logic [DW-1:0]         gap_diff;
   gap_rsp_type           gap_rsp;
   logic                  gap_ok;
   logic [SPEED_BITS-1:0] spd1;
   logic [SPEED_BITS-1:0] spd2;
   logic [SPEED_BITS-1:0] spd3;
   logic [WIDE_BITS:0]    pos;
   logic                  wrap;
   logic [WIDE_BITS:0]    pos2;
   logic [CELL_BITS-1:0]  new_cell;
   logic [LAP_BITS-1:0]   laps_new;
   logic                  we;
   logic [CELL_BITS-1:0]  wcell;
   logic [SPEED_BITS-1:0] wspd;
   logic [LAP_BITS-1:0]   wlaps;

   tacs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // effective road length and car count
   assign eff_len = (cfg.road_length < LEN_BITS'(2)) ? LEN_BITS'(2) : cfg.road_length;
   always_comb begin
      if (cfg.cars_in_use == '0) begin
         eff_n = CMP_BITS'(1);
      end else if (CMP_BITS'(cfg.cars_in_use) > CMP_BITS'(MAX_CARS)) begin
         eff_n = CMP_BITS'(MAX_CARS);
      end else begin
         eff_n = CMP_BITS'(cfg.cars_in_use);
      end
   end

   // handshake
   assign fire      = s_vld_ff & gap_ok & (~o_vld_ff | ~rsp_stall);
   assign req_stall = s_vld_ff & ~fire;
   assign acc       = req_valid & ~req_stall;

   // car chosen at acceptance
   assign c_acc     = (CMP_BITS'(turn_ff) < eff_n) ? turn_ff : '0;
   assign last_acc  = (CMP_BITS'(c_acc) + CMP_BITS'(1)) >= eff_n;
   assign next_addr = c_acc + CAR_BITS'(1);
   assign in_store  = CMPI_BITS'(req_car_index) < CMPI_BITS'(MAX_CARS);

   // the item leaving the stage writes the store at the same edge
   assign bypass_own  = we && (s_car_ff == c_acc);
   assign bypass_next = we && (s_car_ff == next_addr);

   // turn pointer advances as step items enter
   always_ff @(posedge clock) begin
      if (reset) begin
         turn_ff <= '0;
      end else if (acc && req_kind == KIND_STEP) begin
         turn_ff <= last_acc ? '0 : next_addr;
      end
   end

   // stage load and store reads
   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
      end else if (acc) begin
         s_vld_ff <= 1'b1;
      end else if (fire) begin
         s_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s_kind_ff     <= req_kind;
         s_idx_ff      <= req_car_index;
         s_in_store_ff <= in_store;
         s_start_ff    <= CELL_BITS'(req_start_cell);
         s_rnd_ff      <= req_random_value;
         s_last_ff     <= last_acc;
         s_car_ff      <= (req_kind == KIND_STEP) ? c_acc : CAR_BITS'(req_car_index);
         if (bypass_own) begin
            s_own_ff  <= wcell;
            s_spd_ff  <= wspd;
            s_laps_ff <= wlaps;
         end else begin
            s_own_ff <= cell_mem[c_acc];
            if (sl_vld_ff[c_acc]) begin
               s_spd_ff  <= spd_mem[c_acc];
               s_laps_ff <= lap_mem[c_acc];
            end else begin
               s_spd_ff  <= '0;
               s_laps_ff <= '0;
            end
         end
         if (bypass_next) begin
            s_next_ff <= wcell;
         end else begin
            s_next_ff <= cell_mem[next_addr];
         end
      end
   end

   // cell ahead, before this tick
   assign step      = (s_kind_ff == KIND_STEP);
   assign first_eff = (s_car_ff == '0) ? s_own_ff : first_old_ff;
   assign next_cell = s_last_ff ? first_eff : s_next_ff;
   assign gap_diff  = DW'(next_cell) - DW'(s_own_ff) - DW'(1);

   tacs_gap #(
      .DW (DW)
   ) u_gap (
      .clock      (clock),
      .reset      (reset),
      .req_vld    (s_vld_ff & step),
      .gap_diff   (gap_diff),
      .road_cells (eff_len),
      .take       (fire),
      .rsp        (gap_rsp)
   );

   assign gap_ok = ~step | gap_rsp.vld;

   // speed: accelerate, cut to gap, dawdle
   assign spd1 = (s_spd_ff < cfg.speed_limit) ? s_spd_ff + SPEED_BITS'(1) : s_spd_ff;
   assign spd2 = (LEN_BITS'(spd1) > gap_rsp.gap) ? gap_rsp.gap[SPEED_BITS-1:0] : spd1;
   assign spd3 = (spd2 != '0 && THR_BITS'(s_rnd_ff) < cfg.slow_threshold)
                 ? spd2 - SPEED_BITS'(1) : spd2;

   // advance with a single wrap
   assign pos      = (WIDE_BITS + 1)'(s_own_ff) + (WIDE_BITS + 1)'(spd3);
   assign wrap     = pos >= (WIDE_BITS + 1)'(eff_len);
   assign pos2     = wrap ? pos - (WIDE_BITS + 1)'(eff_len) : pos;
   assign new_cell = pos2[CELL_BITS-1:0];
   assign laps_new = s_laps_ff + LAP_BITS'(wrap);

   // store write port
   assign we    = fire & (step | s_in_store_ff);
   assign wcell = step ? new_cell : s_start_ff;
   assign wspd  = step ? spd3 : '0;
   assign wlaps = step ? laps_new : '0;

   always_ff @(posedge clock) begin
      if (we) begin
         cell_mem[s_car_ff] <= wcell;
         spd_mem[s_car_ff]  <= wspd;
         lap_mem[s_car_ff]  <= wlaps;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sl_vld_ff <= '0;
      end else if (we) begin
         sl_vld_ff[s_car_ff] <= 1'b1;
      end
   end

   // first car's cell from before its move
   always_ff @(posedge clock) begin
      if (reset) begin
         first_old_ff <= '0;
      end else if (fire && step && s_car_ff == '0) begin
         first_old_ff <= s_own_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (fire) begin
         o_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         o_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         if (step) begin
            o_car_ff  <= IDX_BITS'(s_car_ff);
            o_cell_ff <= OUT_CELL_BITS'(new_cell);
            o_spd_ff  <= spd3;
            o_laps_ff <= laps_new;
            o_tick_ff <= s_last_ff;
         end else begin
            o_car_ff  <= s_idx_ff;
            o_cell_ff <= s_in_store_ff ? OUT_CELL_BITS'(s_start_ff) : '0;
            o_spd_ff  <= '0;
            o_laps_ff <= '0;
            o_tick_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = o_vld_ff;
   assign rsp_car_id    = o_car_ff;
   assign rsp_new_cell  = o_cell_ff;
   assign rsp_new_speed = o_spd_ff;
   assign rsp_lap_count = o_laps_ff;
   assign rsp_tick_done = o_tick_ff;

endmodule

`default_nettype wire

@@ hdl/tacs_checker.sv @@
// port checks of the car step block and their binding
`default_nettype none

module tacs_checker
   import tacs_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic [IDX_BITS-1:0]      rsp_car_id,
   input wire logic [OUT_CELL_BITS-1:0] rsp_new_cell,
   input wire logic [SPEED_BITS-1:0]    rsp_new_speed,
   input wire logic [LAP_BITS-1:0]      rsp_lap_count,
   input wire logic                     rsp_tick_done
);

   logic [1:0] pend_ff;
   logic [1:0] pend_in;
   logic       in_acc;
   logic       out_acc;

   // items accepted and not yet delivered
   assign in_acc  = req_valid & ~req_stall;
   assign out_acc = rsp_valid & ~rsp_stall;
   assign pend_in = pend_ff + 2'(in_acc) - 2'(out_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // nothing held straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

   // no result without an item behind it
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without an outstanding item");

   // stage and result register full and blocked means no more input
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      pend_ff == 2'd2 && rsp_stall |-> req_stall)
      else $error("input taken with both places full");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_car_id)
         && $stable(rsp_new_cell) && $stable(rsp_new_speed)
         && $stable(rsp_lap_count) && $stable(rsp_tick_done))
      else $error("stalled result changed");

endmodule

bind traffic_automaton_car_step tacs_checker u_tacs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_car_id    (rsp_car_id),
   .rsp_new_cell  (rsp_new_cell),
   .rsp_new_speed (rsp_new_speed),
   .rsp_lap_count (rsp_lap_count),
   .rsp_tick_done (rsp_tick_done)
);

`default_nettype wire
